@@ hw/rtl/dltq_pkg.sv @@
// ---------------------------------------------------------------------------
// dltq_pkg
// Types and constants shared by the delta-list alarm timeline.
// ---------------------------------------------------------------------------
package dltq_pkg;

	localparam int CAPACITY = 64;
	localparam int ID_BITS  = 16;
	localparam int IDX_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int DLY_BITS = 32;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_NOP    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_SHF,
		S_INS_WR,
		S_CAN_RD,
		S_CAN_CMP,
		S_CAN_SUM,
		S_MOV_RD,
		S_MOV_WR,
		S_HEAD_RD,
		S_HEAD_WAIT,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [DLY_BITS-1:0] duration;
		logic [ID_BITS-1:0]  alarm_id;
		logic [6:0]          remove_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [ID_BITS-1:0]  new_id;
		logic                head_valid;
		logic [ID_BITS-1:0]  head_id;
		logic [DLY_BITS-1:0] head_delay;
		logic [6:0]          occupancy;
	} out_item_t;

endpackage

@@ hw/rtl/dltq_ram.sv @@
// ---------------------------------------------------------------------------
// dltq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module dltq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/delta_list_timer_queue.sv @@
// ---------------------------------------------------------------------------
// delta_list_timer_queue
// Ordered alarm timeline kept as a delta list in one RAM (id and delta
// packed into one word); walked one entry per cycle, shifted by a read then a write.
// ---------------------------------------------------------------------------
// Insert walks to its slot, shifts any later entries up and writes; cancel
// searches for the id, folds its delta into the follower and shifts down;
// remove shifts down by n, or just clears the count when n covers all entries.
// One item at a time; an output stall holds the result. Reset clears count
// and next id; RAM contents undefined until written.
module delta_list_timer_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dltq_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output dltq_pkg::out_item_t out_item
);
	import dltq_pkg::*;

	localparam int WORD = ID_BITS + DLY_BITS;

	fsm_t                state_q, state_d;
	in_item_t            req_q;
	logic [CNT_BITS-1:0] count_q, count_d;
	logic [ID_BITS-1:0]  next_id_q, next_id_d;
	logic [CNT_BITS-1:0] pos_q, pos_d;      // walk position
	logic [CNT_BITS-1:0] src_q, src_d;      // move source / destination
	logic [CNT_BITS-1:0] dst_q, dst_d;
	logic [DLY_BITS-1:0] rem_q, rem_d;      // remaining duration / saved delta
	logic [1:0]          status_q, status_d;
	logic [ID_BITS-1:0]  nid_q, nid_d;
	logic                shift_up_q, shift_up_d;
	out_item_t           out_q, out_d;
	logic                out_valid_q, out_valid_d;

	logic                we;
	logic [IDX_BITS-1:0] waddr, raddr;
	logic [WORD-1:0]     wdata, rdata;
	logic [ID_BITS-1:0]  rd_id;
	logic [DLY_BITS-1:0] rd_dly;
	logic [DLY_BITS:0]   sum;

	dltq_ram #(.WIDTH(WORD), .DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_id  = rdata[WORD-1:DLY_BITS];
	assign rd_dly = rdata[DLY_BITS-1:0];
	assign sum    = {1'b0, rd_dly} + {1'b0, rem_q};

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			next_id_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			next_id_q   <= next_id_d;
			out_valid_q <= out_valid_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		req_q      <= (state_q == S_IDLE) ? in_item : req_q;
		pos_q      <= pos_d;
		src_q      <= src_d;
		dst_q      <= dst_d;
		rem_q      <= rem_d;
		status_q   <= status_d;
		nid_q      <= nid_d;
		shift_up_q <= shift_up_d;
		out_q      <= out_d;
	end

	// next state, RAM access and result
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		next_id_d   = next_id_q;
		pos_d       = pos_q;
		src_d       = src_q;
		dst_d       = dst_q;
		rem_d       = rem_q;
		status_d    = status_q;
		nid_d       = nid_q;
		shift_up_d  = shift_up_q;
		out_d       = out_q;
		out_valid_d = out_valid_q;
		we          = 1'b0;
		waddr       = pos_q[IDX_BITS-1:0];
		wdata       = {rd_id, rd_dly};
		raddr       = pos_q[IDX_BITS-1:0];

		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					status_d = ST_OK;
					nid_d    = '0;
					pos_d    = '0;
					rem_d    = in_item.duration;
					case (in_item.req_type)
						REQ_INSERT: begin
							if (count_q >= CNT_BITS'(CAPACITY)) begin
								status_d = ST_FULL;
								state_d  = S_HEAD_RD;
							end else begin
								state_d = S_INS_RD;
							end
						end
						REQ_CANCEL: state_d = S_CAN_RD;
						REQ_REMOVE: begin
							// shift entries down by n
							if ({1'b0, in_item.remove_count} >= (CNT_BITS+1)'(count_q)) begin
								count_d = '0;
								state_d = S_HEAD_RD;
							end else begin
								src_d      = CNT_BITS'(in_item.remove_count);
								dst_d      = '0;
								shift_up_d = 1'b0;
								state_d    = S_MOV_RD;
							end
						end
						default: state_d = S_HEAD_RD;
					endcase
				end
			end

			// insert: walk comparing remaining duration
			S_INS_RD: begin
				raddr = pos_q[IDX_BITS-1:0];
				state_d = (pos_q < count_q) ? S_INS_CMP : S_INS_WR;
			end
			S_INS_CMP: begin
				if (rem_q > rd_dly) begin
					rem_d   = rem_q - rd_dly;
					pos_d   = pos_q + 1'b1;
					raddr   = pos_q[IDX_BITS-1:0] + 1'b1;
					state_d = (pos_q + 1'b1 < count_q) ? S_INS_CMP : S_INS_WR;
				end else begin
					// reduce this entry's delta in place, then open a gap
					we    = 1'b1;
					waddr = pos_q[IDX_BITS-1:0];
					wdata = {rd_id, rd_dly - rem_q};
					src_d = count_q - 1'b1;
					state_d = S_INS_SHF;
				end
			end
			S_INS_SHF: begin
				// move entries [pos..count-1] up by one, top first
				src_d      = src_q;
				dst_d      = src_q + 1'b1;
				shift_up_d = 1'b1;
				state_d    = S_MOV_RD;
			end
			S_INS_WR: begin
				we        = 1'b1;
				waddr     = pos_q[IDX_BITS-1:0];
				wdata     = {next_id_q, rem_q};
				nid_d     = next_id_q;
				next_id_d = next_id_q + 1'b1;
				count_d   = count_q + 1'b1;
				state_d   = S_HEAD_RD;
			end

			// cancel: search for id
			S_CAN_RD: begin
				raddr   = '0;
				state_d = (count_q != '0) ? S_CAN_CMP : S_HEAD_RD;
				if (count_q == '0) begin
					status_d = ST_NOT_FOUND;
				end
			end
			S_CAN_CMP: begin
				if (rd_id == req_q.alarm_id) begin
					rem_d = rd_dly;
					if (pos_q + 1'b1 < count_q) begin
						raddr   = pos_q[IDX_BITS-1:0] + 1'b1;
						state_d = S_CAN_SUM;
					end else begin
						count_d = count_q - 1'b1;
						state_d = S_HEAD_RD;
					end
				end else if (pos_q + 1'b1 < count_q) begin
					pos_d   = pos_q + 1'b1;
					raddr   = pos_q[IDX_BITS-1:0] + 1'b1;
				end else begin
					status_d = ST_NOT_FOUND;
					state_d  = S_HEAD_RD;
				end
			end
			S_CAN_SUM: begin
				// fold the delta into the follower, then shift down by one
				we    = 1'b1;
				waddr = pos_q[IDX_BITS-1:0] + 1'b1;
				wdata = {rd_id, sum[DLY_BITS] ? {DLY_BITS{1'b1}} : sum[DLY_BITS-1:0]};
				src_d      = pos_q + 1'b1;
				dst_d      = pos_q;
				shift_up_d = 1'b0;
				state_d    = S_MOV_RD;
			end

			// generic entry move: one read, one write
			S_MOV_RD: begin
				raddr   = src_q[IDX_BITS-1:0];
				state_d = S_MOV_WR;
			end
			S_MOV_WR: begin
				we    = 1'b1;
				waddr = dst_q[IDX_BITS-1:0];
				wdata = rdata;
				if (shift_up_q) begin
					if (src_q == pos_q) begin
						state_d = S_INS_WR;
					end else begin
						src_d   = src_q - 1'b1;
						dst_d   = src_q;
						state_d = S_MOV_RD;
					end
				end else if (src_q + 1'b1 < count_q) begin
					src_d   = src_q + 1'b1;
					dst_d   = dst_q + 1'b1;
					state_d = S_MOV_RD;
				end else begin
					count_d = dst_q + 1'b1;
					state_d = S_HEAD_RD;
				end
			end

			// read head and publish result
			S_HEAD_RD: begin
				raddr   = '0;
				state_d = S_HEAD_WAIT;
			end
			S_HEAD_WAIT: begin
				if (!out_valid_q || !out_stall) begin
					out_d.status     = status_q;
					out_d.new_id     = nid_q;
					out_d.head_valid = (count_q != '0);
					out_d.head_id    = (count_q != '0) ? rd_id : '0;
					out_d.head_delay = (count_q != '0) ? rd_dly : '0;
					out_d.occupancy  = 7'(count_q);
					out_valid_d      = 1'b1;
					state_d          = S_IDLE;
				end else begin
					raddr   = '0;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				raddr   = '0;
				state_d = S_HEAD_WAIT;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
